// ----- sv/fhs_pkg.sv -----
// -----------------------------------------------------------------------------
// fhs_pkg
// Shared field widths, field types, operation codes and control states for the frame history
// stacker.
// -----------------------------------------------------------------------------
package fhs_pkg;

  // Field widths of the item ports
  localparam int unsigned EnvW    = 4;
  localparam int unsigned ElemW   = 6;
  localparam int unsigned SampleW = 8;
  localparam int unsigned AgeW    = 2;

  typedef logic [EnvW-1:0]    env_t;
  typedef logic [ElemW-1:0]   elem_t;
  typedef logic [SampleW-1:0] sample_t;
  typedef logic [AgeW-1:0]    age_t;

  // Operation codes
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  // Control states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

// ----- sv/fhs_ring_store.sv -----
// -----------------------------------------------------------------------------
// fhs_ring_store
// History memory with one row per (environment, element) ring. A lookup
// reads the row, the next cycle merges the new sample (one slot or the whole
// ring) and writes the row back; the merged row is held for readout.
// -----------------------------------------------------------------------------
module fhs_ring_store #(
  parameter int unsigned ROWS        = 1024,
  parameter int unsigned STACK_DEPTH = 4,
  parameter int unsigned SAMPLE_WIDTH = 8,
  parameter int unsigned RowW        = 10,
  parameter int unsigned SlotW       = 2
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      lookup_i,
  input  logic [RowW-1:0]                           row_i,
  input  fhs_pkg::sample_t                          sample_i,
  input  logic                                      fill_i,
  input  logic [SlotW-1:0]                          slot_i,
  output logic                                      merge_o,
  output logic [STACK_DEPTH-1:0][SAMPLE_WIDTH-1:0]  window_o
);
  import fhs_pkg::*;

  typedef logic [STACK_DEPTH-1:0][SAMPLE_WIDTH-1:0] row_t;

  row_t                    mem [ROWS];
  row_t                    rd_q;
  row_t                    merged;
  row_t                    window_q;
  logic [RowW-1:0]         row_q;
  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic                    fill_q;
  logic [SlotW-1:0]        slot_q;
  logic                    merge_q;

  // Capture the request and read the row
  always_ff @(posedge clk_i) begin
    if (lookup_i) begin
      rd_q     <= mem[row_i];
      row_q    <= row_i;
      sample_q <= SAMPLE_WIDTH'(sample_i);
      fill_q   <= fill_i;
      slot_q   <= slot_i;
    end
  end

  // The merge stage runs in the cycle after each lookup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_q <= 1'b0;
    end else begin
      merge_q <= lookup_i;
    end
  end

  // Overwrite the write slot, or every slot on a refill
  always_comb begin
    for (int s = 0; s < STACK_DEPTH; s++) begin
      merged[s] = (fill_q || (slot_q == SlotW'(s))) ? sample_q : rd_q[s];
    end
  end

  // Write back and hold the window for readout
  always_ff @(posedge clk_i) begin
    if (merge_q) begin
      mem[row_q] <= merged;
      window_q   <= merged;
    end
  end

  assign merge_o  = merge_q;
  assign window_o = window_q;

endmodule

// ----- sv/frame_history_stacker.sv -----
// -----------------------------------------------------------------------------
// frame_history_stacker
// Frame-stacking ring buffer: keeps the last STACK_DEPTH samples of every
// environment and element and emits the window, oldest first, per push.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, operation_i,       | input
//           | env_index_i, element_index_i, sample_i,   |
//           | episode_start_i, end_of_step_i            |
//   out     | out_valid_o/out_ready_i, history_sample_o,| output
//           | age_slot_o, last_of_window_o              |
//
// A push first reads and merges its row in the single-port history memory,
// then emits the window one sample per cycle while out_ready_i is high.
// The next item is taken in the cycle the last sample leaves.
// A clear or an out-of-range push emits nothing.
// Output stalls hold the window; reset clears the control registers, not the history memory.
// -----------------------------------------------------------------------------
module frame_history_stacker #(
  parameter int unsigned STACK_DEPTH    = 4,
  parameter int unsigned ENV_COUNT      = 16,
  parameter int unsigned FRAME_ELEMENTS = 64,
  parameter int unsigned SAMPLE_WIDTH   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  fhs_pkg::env_t    env_index_i,
  input  fhs_pkg::elem_t   element_index_i,
  input  fhs_pkg::sample_t sample_i,
  input  logic             episode_start_i,
  input  logic             end_of_step_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fhs_pkg::sample_t history_sample_o,
  output fhs_pkg::age_t    age_slot_o,
  output logic             last_of_window_o
);
  import fhs_pkg::*;

  localparam int unsigned Rows  = ENV_COUNT * FRAME_ELEMENTS;
  localparam int unsigned RowW  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned SlotW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  state_e                                    state_q, state_d;
  logic [SlotW-1:0]                          wp_q, wp_d;
  logic                                      primed_q, primed_d;
  logic [SlotW-1:0]                          ptr_q, ptr_d;
  logic [SlotW-1:0]                          cnt_q, cnt_d;
  logic [SlotW-1:0]                          start_q;
  logic [SlotW-1:0]                          wp_next;
  logic [SlotW-1:0]                          ptr_next;
  logic [RowW-1:0]                           row_idx;
  logic                                      in_range;
  logic                                      in_fire;
  logic                                      out_fire;
  logic                                      is_push;
  logic                                      last_beat;
  logic                                      merge;
  logic [STACK_DEPTH-1:0][SAMPLE_WIDTH-1:0]  window;

  // Decode the incoming item
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_range = (32'(env_index_i) < ENV_COUNT) && (32'(element_index_i) < FRAME_ELEMENTS);
  assign is_push  = (op_e'(operation_i) == OP_PUSH) && in_range;
  assign row_idx  = RowW'(32'(env_index_i) * 32'(FRAME_ELEMENTS) + 32'(element_index_i));
  assign wp_next  = (wp_q == SlotW'(STACK_DEPTH - 1)) ? '0 : wp_q + SlotW'(1);
  assign ptr_next = (ptr_q == SlotW'(STACK_DEPTH - 1)) ? '0 : ptr_q + SlotW'(1);
  assign last_beat = (cnt_q == SlotW'(STACK_DEPTH - 1));

  // Take a new item when idle or as the last sample leaves
  assign in_ready_o = (state_q == ST_IDLE) ||
                      ((state_q == ST_EMIT) && last_beat && out_ready_i);

  fhs_ring_store #(
    .ROWS         (Rows),
    .STACK_DEPTH  (STACK_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .RowW         (RowW),
    .SlotW        (SlotW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .lookup_i (in_fire && is_push),
    .row_i    (row_idx),
    .sample_i (sample_i),
    .fill_i   (!primed_q || episode_start_i),
    .slot_i   (wp_q),
    .merge_o  (merge),
    .window_o (window)
  );

  // Remember where the window starts: the slot after the write slot
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q <= wp_next;
    end
  end

  // Sequence lookup and readout; advance write position on end of step, reset it on a clear
  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    primed_d = primed_q;
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_LOOK: begin
        if (merge) begin
          state_d = ST_EMIT;
          ptr_d   = start_q;
          cnt_d   = '0;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          ptr_d = ptr_next;
          cnt_d = cnt_q + SlotW'(1);
          if (last_beat) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (in_fire) begin
      if (op_e'(operation_i) == OP_CLEAR) begin
        wp_d     = '0;
        primed_d = 1'b0;
      end else begin
        if (end_of_step_i) begin
          wp_d     = wp_next;
          primed_d = 1'b1;
        end
        state_d = is_push ? ST_LOOK : ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wp_q     <= '0;
      primed_q <= 1'b0;
      ptr_q    <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      primed_q <= primed_d;
      ptr_q    <= ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Present the window one sample per cycle, holding it while out_ready_i is low
  assign out_valid_o      = (state_q == ST_EMIT);
  assign history_sample_o = SampleW'(window[ptr_q]);
  assign age_slot_o       = AgeW'(cnt_q);
  assign last_of_window_o = last_beat;

endmodule

// ----- bench/tb_frame_history_stacker.sv -----
// -----------------------------------------------------------------------------
// tb_frame_history_stacker
// Self-checking bench for the frame history stacker. A scoreboard class keeps
// its own copy of every history ring, the shared write position and the
// primed flag, and builds the expected window for each accepted push.
// Directed items cover the corners, then random items run in three idling
// phases, with one long output hold-off that backs up the input channel.
// -----------------------------------------------------------------------------
module tb_frame_history_stacker;
  import fhs_pkg::*;

  localparam int unsigned STACK_DEPTH    = 4;
  localparam int unsigned ENV_COUNT      = 16;
  localparam int unsigned FRAME_ELEMENTS = 64;
  localparam int unsigned SAMPLE_WIDTH   = 8;

  localparam int unsigned ITEMS_PER_PHASE = 54;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned DRAIN_CYCLES    = 4 * (STACK_DEPTH + 1);

  // One sample of an expected history window
  typedef struct packed {
    sample_t smp;
    age_t    age;
    logic    last;
  } window_entry_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: ring store prediction and window checking
  // ---------------------------------------------------------------------------
  class window_scoreboard;
    sample_t       ring_mem [ENV_COUNT][FRAME_ELEMENTS][STACK_DEPTH];
    int unsigned   wr_pos;
    bit            primed;
    window_entry_t window_q[$];
    int unsigned   errors;

    function new();
      wr_pos  = 0;
      primed  = 1'b0;
      errors  = 0;
    endfunction

    // Apply one accepted item and queue the window it emits
    function void note_item(op_e op, env_t env, elem_t elem, sample_t smp,
                            logic start, logic eos);
      int unsigned   oldest;
      int unsigned   slot;
      window_entry_t entry;
      oldest = (wr_pos + 1) % STACK_DEPTH;
      if (op == OP_CLEAR) begin
        wr_pos = 0;
        primed = 1'b0;
        return;
      end
      if (env < ENV_COUNT && elem < FRAME_ELEMENTS) begin
        // Refill the whole ring when unprimed or on an episode start
        if (!primed || start) begin
          for (int s = 0; s < STACK_DEPTH; s++) ring_mem[env][elem][s] = smp;
        end else begin
          ring_mem[env][elem][wr_pos] = smp;
        end
        // Queue the window, oldest first
        for (int s = 0; s < STACK_DEPTH; s++) begin
          slot       = (oldest + s) % STACK_DEPTH;
          entry.smp  = ring_mem[env][elem][slot];
          entry.age  = age_t'(s);
          entry.last = (s + 1 == STACK_DEPTH);
          window_q.push_back(entry);
        end
      end
      if (eos) begin
        wr_pos = oldest;
        primed = 1'b1;
      end
    endfunction

    // Compare one accepted window sample with the oldest expectation
    function void check_sample(sample_t smp, age_t age, logic last);
      window_entry_t exp_e;
      if (window_q.size() == 0) begin
        $error("unexpected window sample: history_sample=%0h age_slot=%0d last=%0b",
               smp, age, last);
        errors++;
        return;
      end
      exp_e = window_q.pop_front();
      if (smp !== exp_e.smp) begin
        $error("history_sample: expected %0h, actual %0h", exp_e.smp, smp);
        errors++;
      end
      if (age !== exp_e.age) begin
        $error("age_slot: expected %0d, actual %0d", exp_e.age, age);
        errors++;
      end
      if (last !== exp_e.last) begin
        $error("last_of_window: expected %0b, actual %0b", exp_e.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return window_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals
  // ---------------------------------------------------------------------------
  logic    clk_i           = 1'b0;
  logic    rst_ni          = 1'b0;
  logic    in_valid_i      = 1'b0;
  logic    in_ready_o;
  logic    operation_i     = OP_PUSH;
  env_t    env_index_i     = '0;
  elem_t   element_index_i = '0;
  sample_t sample_i        = '0;
  logic    episode_start_i = 1'b0;
  logic    end_of_step_i   = 1'b0;
  logic    out_valid_o;
  logic    out_ready_i     = 1'b0;
  sample_t history_sample_o;
  age_t    age_slot_o;
  logic    last_of_window_o;

  window_scoreboard sb;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_req  = 1'b0;
  int unsigned quiet_cycles  = 0;

  // Stimulus-side view of which rings are fully written and whether primed
  bit gen_written [ENV_COUNT][FRAME_ELEMENTS];
  bit gen_primed = 1'b0;

  frame_history_stacker #(
    .STACK_DEPTH   (STACK_DEPTH),
    .ENV_COUNT     (ENV_COUNT),
    .FRAME_ELEMENTS(FRAME_ELEMENTS),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .env_index_i     (env_index_i),
    .element_index_i (element_index_i),
    .sample_i        (sample_i),
    .episode_start_i (episode_start_i),
    .end_of_step_i   (end_of_step_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .history_sample_o(history_sample_o),
    .age_slot_o      (age_slot_o),
    .last_of_window_o(last_of_window_o)
  );

  // Clock
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Driver: offer one item, idling at random first, and hold it until taken.
  // A primed push to a ring never written gets an episode start so that no
  // unwritten slot is ever read.
  // ---------------------------------------------------------------------------
  task automatic send_item(input op_e op, input env_t env, input elem_t elem,
                           input sample_t smp, input logic start, input logic eos);
    logic start_fixed;
    start_fixed = start;
    if (op == OP_PUSH) begin
      if (gen_primed && !gen_written[env][elem]) start_fixed = 1'b1;
      gen_written[env][elem] = 1'b1;
      if (eos) gen_primed = 1'b1;
    end else begin
      gen_primed = 1'b0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    env_index_i     <= env;
    element_index_i <= elem;
    sample_i        <= smp;
    episode_start_i <= start_fixed;
    end_of_step_i   <= eos;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver: random ready, with a long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Input monitor: predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_item(op_e'(operation_i), env_index_i, element_index_i, sample_i,
                   episode_start_i, end_of_step_i);
    end
  end

  // Output monitor: check every accepted window sample
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_sample(history_sample_o, age_slot_o, last_of_window_o);
    end
  end

  // Watchdog: end the run after too many cycles without any handshake
  initial begin : watchdog
    wait (rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    op_e     r_op;
    env_t    r_env;
    elem_t   r_elem;
    sample_t r_smp;
    logic    r_start;
    logic    r_eos;

    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 32;
    recv_idle_pct = 65;

    // Unprimed pushes fill whole rings; field extremes
    send_item(OP_PUSH, 4'd0,  6'd0,  8'h00, 1'b0, 1'b0);
    send_item(OP_PUSH, 4'd15, 6'd63, 8'hFF, 1'b0, 1'b1);
    // Walk the write position all the way around the ring
    send_item(OP_PUSH, 4'd0,  6'd0,  8'h11, 1'b0, 1'b1);
    send_item(OP_PUSH, 4'd0,  6'd0,  8'h22, 1'b0, 1'b1);
    send_item(OP_PUSH, 4'd0,  6'd0,  8'h33, 1'b0, 1'b1);
    send_item(OP_PUSH, 4'd0,  6'd0,  8'h44, 1'b0, 1'b1);
    send_item(OP_PUSH, 4'd0,  6'd0,  8'h55, 1'b0, 1'b0);
    // Episode start refills a primed ring
    send_item(OP_PUSH, 4'd15, 6'd63, 8'hA5, 1'b1, 1'b0);
    send_item(OP_PUSH, 4'd15, 6'd63, 8'h5A, 1'b0, 1'b1);
    send_item(OP_PUSH, 4'd15, 6'd63, 8'hC3, 1'b1, 1'b1);
    send_item(OP_PUSH, 4'd15, 6'd63, 8'h3C, 1'b0, 1'b1);
    // Clear ignores its other fields, end of step included
    send_item(OP_CLEAR, 4'd15, 6'd63, 8'hFF, 1'b1, 1'b1);
    send_item(OP_PUSH, 4'd0,  6'd0,  8'h80, 1'b0, 1'b0);
    send_item(OP_PUSH, 4'd15, 6'd63, 8'h01, 1'b0, 1'b0);
    send_item(OP_CLEAR, 4'd0,  6'd0,  8'h00, 1'b0, 1'b0);
    send_item(OP_CLEAR, 4'd10, 6'd42, 8'h96, 1'b0, 1'b1);
    // Primed again, then an ordinary shift on a mid-range ring
    send_item(OP_PUSH, 4'd7,  6'd32, 8'h7F, 1'b0, 1'b1);
    send_item(OP_PUSH, 4'd7,  6'd32, 8'h01, 1'b0, 1'b0);
    send_item(OP_PUSH, 4'd8,  6'd31, 8'hFE, 1'b0, 1'b1);
    send_item(OP_PUSH, 4'd7,  6'd32, 8'h02, 1'b0, 1'b1);

    // Random items in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_off_req  = 1'b1;
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        // Mostly pushes to a few busy rings, so histories grow deep
        r_op    = ($urandom_range(0, 99) < 4) ? OP_CLEAR : OP_PUSH;
        r_env   = ($urandom_range(0, 99) < 70) ? env_t'($urandom_range(0, 3))
                                               : env_t'($urandom_range(0, 15));
        r_elem  = ($urandom_range(0, 99) < 70) ? elem_t'($urandom_range(0, 7))
                                               : elem_t'($urandom_range(0, 63));
        r_smp   = sample_t'($urandom_range(0, 255));
        r_start = ($urandom_range(0, 99) < 10);
        r_eos   = ($urandom_range(0, 99) < 30);
        send_item(r_op, r_env, r_elem, r_smp, r_start, r_eos);
      end
    end
    in_valid_i <= 1'b0;

    // Drain the remaining windows, then idle for DRAIN_CYCLES
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/fhs_pkg.sv
sv/fhs_ring_store.sv
sv/frame_history_stacker.sv
bench/tb_frame_history_stacker.sv
